@@ design/dkdi_pkg.sv @@
// Shared types and constants for the dual-kernel dot product interpolator.
// Used by dkdi_ctrl, dkdi_datapath and dual_kernel_dot_interpolate.
package dkdi_pkg;

    localparam int KERNEL_SIZE = 32;
    localparam int TAP_W       = $clog2(KERNEL_SIZE);

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int FACTOR_W = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = 40;
    localparam int DIFF_W   = ACC_W + 1;
    localparam int BLEND_W  = DIFF_W + FACTOR_W + 1;
    localparam int FRAC_SH  = 31;
    localparam int RES_W    = 21;
    localparam int ROUND_W  = BLEND_W - FRAC_SH;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIFF,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic acc_en;
        logic diff_en;
        logic mul_en;
        logic out_load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

@@ design/dkdi_ctrl.sv @@
// Controller state machine and tap counter of the interpolator.
// Depends on dkdi_pkg; drives the command struct of dkdi_datapath.
module dkdi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dkdi_pkg::status_t status,
    output dkdi_pkg::cmd_t    cmd
);

    dkdi_pkg::state_t            state_reg, state_next;
    logic [dkdi_pkg::TAP_W-1:0]  tap_count_reg, tap_count_next;
    logic                        last_tap;

    assign last_tap = (tap_count_reg == dkdi_pkg::TAP_W'(dkdi_pkg::KERNEL_SIZE - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dkdi_pkg::ST_IDLE;
            tap_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            tap_count_reg <= tap_count_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        tap_count_next = tap_count_reg;
        case (state_reg)
            dkdi_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = dkdi_pkg::ST_ACC;
            end
            dkdi_pkg::ST_ACC: begin
                if (last_tap) begin
                    state_next     = dkdi_pkg::ST_DIFF;
                    tap_count_next = '0;
                end else begin
                    state_next     = dkdi_pkg::ST_IDLE;
                    tap_count_next = tap_count_reg + 1'b1;
                end
            end
            dkdi_pkg::ST_DIFF: state_next = dkdi_pkg::ST_MUL;
            dkdi_pkg::ST_MUL:  state_next = dkdi_pkg::ST_OUT;
            dkdi_pkg::ST_OUT: begin
                if (!status.out_busy) state_next = dkdi_pkg::ST_IDLE;
            end
            default: state_next = dkdi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            dkdi_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            dkdi_pkg::ST_ACC:  cmd.acc_en  = 1'b1;
            dkdi_pkg::ST_DIFF: cmd.diff_en = 1'b1;
            dkdi_pkg::ST_MUL:  cmd.mul_en  = 1'b1;
            dkdi_pkg::ST_OUT: begin
                // The result is loaded only once the output register is free.
                cmd.out_load = !status.out_busy;
                cmd.clear    = !status.out_busy;
            end
            default: cmd = '0;
        endcase
    end

    a_acc_after_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dkdi_pkg::ST_ACC) |-> $past(cmd.capture))
        else $error("accumulate step without a captured item");

    a_tap_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_count_reg <= dkdi_pkg::TAP_W'(dkdi_pkg::KERNEL_SIZE - 1))
        else $error("tap counter beyond kernel size");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.out_busy)
        else $error("result loaded over a pending result");

    a_counter_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dkdi_pkg::ST_DIFF) |-> (tap_count_reg == '0))
        else $error("tap counter not cleared after last tap");

endmodule

@@ design/dkdi_datapath.sv @@
// Datapath of the interpolator: tap multipliers, accumulators, blend and rounding.
// Depends on dkdi_pkg; controlled by dkdi_ctrl through the command struct.
module dkdi_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dkdi_pkg::cmd_t                       cmd,
    output dkdi_pkg::status_t                    status,
    input  logic signed [dkdi_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [dkdi_pkg::COEF_W-1:0]   coef_a,
    input  logic signed [dkdi_pkg::COEF_W-1:0]   coef_b,
    input  logic        [dkdi_pkg::FACTOR_W-1:0] interp_factor,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [dkdi_pkg::RES_W-1:0]    result,
    output logic                                 saturated
);

    logic signed [dkdi_pkg::PROD_W-1:0]   prod_a_reg, prod_b_reg;
    logic        [dkdi_pkg::FACTOR_W-1:0] factor_reg;
    logic signed [dkdi_pkg::ACC_W-1:0]    acc_a_reg, acc_b_reg;
    logic signed [dkdi_pkg::DIFF_W-1:0]   diff_reg;
    logic signed [dkdi_pkg::BLEND_W-1:0]  blend_reg;
    logic signed [dkdi_pkg::BLEND_W-1:0]  total;
    logic signed [dkdi_pkg::ROUND_W-1:0]  rounded;
    logic                                 fits;
    logic signed [dkdi_pkg::RES_W-1:0]    res_next;
    logic                                 out_valid_reg;
    logic signed [dkdi_pkg::RES_W-1:0]    result_reg;
    logic                                 saturated_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            prod_a_reg <= sample * coef_a;
            prod_b_reg <= sample * coef_b;
            factor_reg <= interp_factor;
        end
        if (cmd.diff_en) begin
            diff_reg <= dkdi_pkg::DIFF_W'(acc_b_reg) - dkdi_pkg::DIFF_W'(acc_a_reg);
        end
        if (cmd.mul_en) begin
            blend_reg <= dkdi_pkg::BLEND_W'(diff_reg) * $signed({1'b0, factor_reg});
        end
        if (cmd.out_load) begin
            result_reg    <= res_next;
            saturated_reg <= !fits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_a_reg     <= '0;
            acc_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                acc_a_reg <= '0;
                acc_b_reg <= '0;
            end else if (cmd.acc_en) begin
                acc_a_reg <= acc_a_reg + dkdi_pkg::ACC_W'(prod_a_reg);
                acc_b_reg <= acc_b_reg + dkdi_pkg::ACC_W'(prod_b_reg);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Blend in Q.46: acc_a * 2^16 + diff * f, plus half an output LSB for rounding.
    always_comb begin
        total = dkdi_pkg::BLEND_W'(acc_a_reg);
        total = (total <<< dkdi_pkg::FACTOR_W) + blend_reg
              + (dkdi_pkg::BLEND_W'(1) << (dkdi_pkg::FRAC_SH - 1));
        rounded = total[dkdi_pkg::BLEND_W-1:dkdi_pkg::FRAC_SH];
        fits = (rounded[dkdi_pkg::ROUND_W-1:dkdi_pkg::RES_W-1] == '0) ||
               (rounded[dkdi_pkg::ROUND_W-1:dkdi_pkg::RES_W-1] == '1);
        if (fits) begin
            res_next = rounded[dkdi_pkg::RES_W-1:0];
        end else if (rounded[dkdi_pkg::ROUND_W-1]) begin
            res_next = {1'b1, {(dkdi_pkg::RES_W-1){1'b0}}};
        end else begin
            res_next = {1'b0, {(dkdi_pkg::RES_W-1){1'b1}}};
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign result          = result_reg;
    assign saturated       = saturated_reg;

endmodule

@@ design/dual_kernel_dot_interpolate.sv @@
// Top level of the dual-kernel dot product interpolator.
// Depends on dkdi_pkg, dkdi_ctrl and dkdi_datapath.
//
// Each input item is one tap: a Q1.15 sample and the matching Q1.15 coefficients
// of kernels A and B, plus a Q0.16 blend factor that is used only on the last tap.
// The block forms both dot products over KERNEL_SIZE taps; on the last tap it
// sends one result item sum_a + f*(sum_b - sum_a), rounded to Q.15 (ties up)
// and saturated to 21 bits, with a flag when clipping occurred. Then the tap
// counter and both accumulators clear for the next kernel.
// Each ordinary tap is captured (both 16x16 products) and then accumulated; no
// new tap is taken during the accumulate step. The last tap is followed by the
// difference, the 41x17 blend multiply and round/saturate steps in the datapath,
// and the round/saturate step waits while the output register is still busy.
// The result waits in an output register, and taps of the next kernel are
// taken while it waits. A further result is held back until the receiver has
// taken the previous one, and input stalls for that time.
// A synchronous low aresetn clears the counter, accumulators and output valid.
module dual_kernel_dot_interpolate (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] sample, [31:16] coef_a, [47:32] coef_b, [63:48] interp_factor
    input  logic [dkdi_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [20:0] result, [21] saturated, [23:22] zero
    output logic [dkdi_pkg::OUT_DATA_W-1:0]     m_tdata
);

    dkdi_pkg::cmd_t                     cmd;
    dkdi_pkg::status_t                  status;
    logic signed [dkdi_pkg::RES_W-1:0]  result;
    logic                               saturated;

    dkdi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dkdi_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .sample        ($signed(s_tdata[15:0])),
        .coef_a        ($signed(s_tdata[31:16])),
        .coef_b        ($signed(s_tdata[47:32])),
        .interp_factor (s_tdata[63:48]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result        (result),
        .saturated     (saturated)
    );

    assign m_tdata = {2'b00, saturated, result};

endmodule

@@ verif/tb_dual_kernel_dot_interpolate.sv @@
// Self-checking testbench for dual_kernel_dot_interpolate: taps stream in, and each
// result is checked against a bit-exact predictor of the two dot products and the blend.
// Depends on dkdi_pkg and the design sources of dual_kernel_dot_interpolate.
`timescale 1ns / 100ps

module tb_dual_kernel_dot_interpolate;

    localparam longint RES_MAX      = 1048575;
    localparam longint RES_MIN      = -1048576;
    localparam int     STALL_LIMIT  = 5000;
    localparam int     TAIL_CYCLES  = 20;
    localparam int     RANDOM_ITEMS = 704;

    typedef struct {
        logic [dkdi_pkg::RES_W-1:0] value;
        logic                       sat;
    } blend_result_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [dkdi_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [dkdi_pkg::OUT_DATA_W-1:0]  m_tdata;

    // Predictor state: taps taken so far and the two Q.30 dot products.
    int     taps_taken;
    longint dot_a_q30;
    longint dot_b_q30;

    blend_result_t pending_blends[$];
    int            fail_count;
    int            idle_pct;
    int            quiet_cycles;

    dual_kernel_dot_interpolate dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Folds one accepted tap into the dot products; on the last tap it queues the blend.
    task automatic fold_tap(input logic [15:0] smp, input logic [15:0] ca,
                            input logic [15:0] cb, input bit [15:0] fct);
        longint        f_q16;
        longint        blend_q46;
        longint        rounded;
        blend_result_t exp_res;
        f_q16 = fct;
        dot_a_q30 += longint'($signed(smp)) * longint'($signed(ca));
        dot_b_q30 += longint'($signed(smp)) * longint'($signed(cb));
        taps_taken++;
        if (taps_taken == dkdi_pkg::KERNEL_SIZE) begin
            blend_q46 = dot_a_q30 * 65536 + (dot_b_q30 - dot_a_q30) * f_q16;
            // Arithmetic shift of a signed value is a floor, so ties go up.
            rounded = (blend_q46 + (longint'(1) <<< 30)) >>> dkdi_pkg::FRAC_SH;
            exp_res.sat = 1'b0;
            if (rounded > RES_MAX) begin
                rounded = RES_MAX;
                exp_res.sat = 1'b1;
            end else if (rounded < RES_MIN) begin
                rounded = RES_MIN;
                exp_res.sat = 1'b1;
            end
            exp_res.value = rounded[dkdi_pkg::RES_W-1:0];
            pending_blends.push_back(exp_res);
            taps_taken = 0;
            dot_a_q30  = 0;
            dot_b_q30  = 0;
        end
    endtask

    // Offers one tap after a random gap and returns once it has been taken.
    // tvalid is only lowered during a gap, so back-to-back taps keep it high.
    task automatic send_tap(input logic [15:0] smp, input logic [15:0] ca,
                            input logic [15:0] cb, input logic [15:0] fct);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {fct, cb, ca, smp};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        fold_tap(smp, ca, cb, fct);
    endtask

    task automatic send_flat_kernel(input logic [15:0] smp, input logic [15:0] ca,
                                    input logic [15:0] cb, input logic [15:0] fct);
        for (int i = 0; i < dkdi_pkg::KERNEL_SIZE; i++) begin
            send_tap(smp, ca, cb, (i == dkdi_pkg::KERNEL_SIZE - 1) ? fct : 16'(i * 2049));
        end
    endtask

    function automatic logic [15:0] pick_value(input int mode);
        logic [15:0] v;
        case (mode)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 512) - 256);
            2: v = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: v = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_factor();
        logic [15:0] f;
        case ($urandom_range(0, 5))
            0: f = 16'h0000;
            1: f = 16'hFFFF;
            default: f = 16'($urandom);
        endcase
        return f;
    endfunction

    // Largest products: a kernel with all taps at -1.0 overflows the Q.15 range and clips high.
    task automatic test_saturation();
        send_flat_kernel(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_flat_kernel(16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_flat_kernel(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_flat_kernel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // A single tap worth exactly half an output step checks the tie direction.
    task automatic test_rounding_ties();
        logic [15:0] half_step[2];
        half_step[0] = 16'h4000;
        half_step[1] = 16'hC000;
        foreach (half_step[k]) begin
            for (int i = 0; i < dkdi_pkg::KERNEL_SIZE; i++) begin
                if (i == 0)
                    send_tap(16'h0001, half_step[k], 16'h0000, 16'hFFFF);
                else
                    send_tap(16'h0000, 16'h0000, 16'h0000,
                             (i == dkdi_pkg::KERNEL_SIZE - 1) ? 16'h0000 : 16'hFFFF);
            end
        end
    endtask

    // The blend at both ends of the factor range, with the kernels far apart.
    task automatic test_factor_extremes();
        send_flat_kernel(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_flat_kernel(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
        send_flat_kernel(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001);
    endtask

    task automatic send_random_kernel();
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < dkdi_pkg::KERNEL_SIZE; i++) begin
            send_tap(pick_value(mode), pick_value(mode), pick_value(mode),
                     (i == dkdi_pkg::KERNEL_SIZE - 1) ? pick_factor() : 16'($urandom));
        end
    endtask

    task automatic test_random_kernels();
        for (int n = 0; n < RANDOM_ITEMS; n += dkdi_pkg::KERNEL_SIZE) begin
            send_random_kernel();
        end
    endtask

    // Several kernels at full rate on both sides, with no gaps at all.
    task automatic test_full_rate();
        int saved_pct;
        saved_pct = idle_pct;
        idle_pct  = 0;
        repeat (6) send_random_kernel();
        idle_pct  = saved_pct;
    endtask

    // The sender holds off until every outstanding result has been taken.
    task automatic test_drain_pause();
        send_random_kernel();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_blends.size() != 0) @(posedge aclk);
        send_random_kernel();
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Result checker: each taken result is matched against the oldest expected blend.
    always @(posedge aclk) begin
        blend_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blends.size() == 0) begin
                $error("unexpected result item: m_tdata %h", m_tdata);
                fail_count++;
            end else begin
                exp_res = pending_blends.pop_front();
                if (m_tdata[dkdi_pkg::RES_W-1:0] !== exp_res.value) begin
                    $error("result: expected %0d, actual %0d",
                           $signed(exp_res.value), $signed(m_tdata[dkdi_pkg::RES_W-1:0]));
                    fail_count++;
                end
                if (m_tdata[dkdi_pkg::RES_W] !== exp_res.sat) begin
                    $error("saturated: expected %0b, actual %0b",
                           exp_res.sat, m_tdata[dkdi_pkg::RES_W]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        taps_taken   = 0;
        dot_a_q30    = 0;
        dot_b_q30    = 0;
        fail_count   = 0;
        idle_pct     = 18;
        quiet_cycles = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_saturation();
        test_rounding_ties();
        test_factor_extremes();
        test_full_rate();
        test_drain_pause();
        test_random_kernels();

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_blends.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
